// ===== design/tfn_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared widths and types for the triangle face normal pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int IN_W        = 16;
    localparam int EW          = COORD_WIDTH + 1;
    localparam int PW          = 2 * EW;
    localparam int CXW         = PW + 1;
    localparam int KEEP        = 16;
    localparam int SHW         = $clog2(CXW - KEEP + 1);
    localparam int SQW         = 2 * KEEP;
    localparam int SUMW        = SQW + 2;
    localparam int REMW        = SUMW + 1;
    localparam int QW          = 31;
    localparam int RTW         = 16;
    localparam int OUT_W       = 16;
    localparam int FRAC_OUT    = 14;
    localparam logic [OUT_W-1:0] ONE_OUT = OUT_W'(1 << FRAC_OUT);

    typedef struct packed {
        logic [2:0] neg;
        logic       degen;
    } side_t;

endpackage
`default_nettype wire

// ===== design/tfn_cross.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tfn_cross
// Edge vectors, six partial products and the cross product, three stages.
// ----------------------------------------------------------------------------
module tfn_cross import tfn_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic                  vld_in,
    input  wire logic [IN_W-1:0]       p1 [3],
    input  wire logic [IN_W-1:0]       p2 [3],
    input  wire logic [IN_W-1:0]       p3 [3],
    output logic                       vld_out,
    output logic signed [CXW-1:0]      cross_prod [3]
);

    logic signed [EW-1:0]  e1_reg [3];
    logic signed [EW-1:0]  e2_reg [3];
    logic signed [PW-1:0]  pa_reg [3];
    logic signed [PW-1:0]  pb_reg [3];
    logic signed [CXW-1:0] c_reg  [3];
    logic [2:0]            vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], vld_in};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                e1_reg[i] <= EW'($signed(p2[i][COORD_WIDTH-1:0]))
                           - EW'($signed(p1[i][COORD_WIDTH-1:0]));
                e2_reg[i] <= EW'($signed(p3[i][COORD_WIDTH-1:0]))
                           - EW'($signed(p1[i][COORD_WIDTH-1:0]));
            end
            pa_reg[0] <= e1_reg[1] * e2_reg[2];
            pb_reg[0] <= e1_reg[2] * e2_reg[1];
            pa_reg[1] <= e1_reg[2] * e2_reg[0];
            pb_reg[1] <= e1_reg[0] * e2_reg[2];
            pa_reg[2] <= e1_reg[0] * e2_reg[1];
            pb_reg[2] <= e1_reg[1] * e2_reg[0];
            for (int i = 0; i < 3; i++) begin
                c_reg[i] <= CXW'(pa_reg[i]) - CXW'(pb_reg[i]);
            end
        end
    end

    assign vld_out    = vld_reg[2];
    assign cross_prod = c_reg;

endmodule
`default_nettype wire

// ===== design/tfn_scale.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tfn_scale
// Magnitudes, common normalizing shift, squares and their sum.
// ----------------------------------------------------------------------------
module tfn_scale import tfn_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic                  vld_in,
    input  wire logic signed [CXW-1:0] cross_prod [3],
    output logic                       vld_out,
    output logic [SQW-1:0]             sq [3],
    output logic [SUMW-1:0]            sum,
    output side_t                      side
);

    logic [CXW-1:0]  mag_a_reg [3];
    side_t           side_a_reg;
    logic [CXW-1:0]  mag_b_reg [3];
    logic [SHW-1:0]  sh_b_reg;
    side_t           side_b_reg;
    logic [KEEP-1:0] m_c_reg [3];
    side_t           side_c_reg;
    logic [SQW-1:0]  sq_d_reg [3];
    side_t           side_d_reg;
    logic [SQW-1:0]  sq_e_reg [3];
    logic [SUMW-1:0] sum_e_reg;
    side_t           side_e_reg;
    logic [4:0]      vld_reg;

    logic [CXW-1:0]  or_v;
    logic [SHW-1:0]  sh_next;

    always_comb begin
        or_v    = mag_a_reg[0] | mag_a_reg[1] | mag_a_reg[2];
        sh_next = '0;
        for (int k = KEEP; k < CXW; k++) begin
            if (or_v[k]) begin
                sh_next = SHW'(k - KEEP + 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[3:0], vld_in};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                mag_a_reg[i]      <= cross_prod[i][CXW-1] ? CXW'(-cross_prod[i])
                                                          : CXW'(cross_prod[i]);
                side_a_reg.neg[i] <= cross_prod[i][CXW-1];
            end
            side_a_reg.degen <= (cross_prod[0] == '0) && (cross_prod[1] == '0)
                             && (cross_prod[2] == '0);

            mag_b_reg  <= mag_a_reg;
            sh_b_reg   <= sh_next;
            side_b_reg <= side_a_reg;

            for (int i = 0; i < 3; i++) begin
                m_c_reg[i] <= KEEP'(mag_b_reg[i] >> sh_b_reg);
            end
            side_c_reg <= side_b_reg;

            for (int i = 0; i < 3; i++) begin
                sq_d_reg[i] <= m_c_reg[i] * m_c_reg[i];
            end
            side_d_reg <= side_c_reg;

            sq_e_reg   <= sq_d_reg;
            sum_e_reg  <= SUMW'(sq_d_reg[0]) + SUMW'(sq_d_reg[1]) + SUMW'(sq_d_reg[2]);
            side_e_reg <= side_d_reg;
        end
    end

    assign vld_out = vld_reg[4];
    assign sq      = sq_e_reg;
    assign sum     = sum_e_reg;
    assign side    = side_e_reg;

endmodule
`default_nettype wire

// ===== design/tfn_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tfn_div
// Pipelined restoring divider, one quotient bit per stage, three lanes:
// quotient = floor(sq * 2^30 / sum).
// ----------------------------------------------------------------------------
module tfn_div import tfn_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              vld_in,
    input  wire logic [SQW-1:0]    sq [3],
    input  wire logic [SUMW-1:0]   sum,
    input  wire side_t             side_in,
    output logic                   vld_out,
    output logic [QW-1:0]          quo [3],
    output side_t                  side_out
);

    logic [REMW-1:0] rem_reg   [QW][3];
    logic [REMW-1:0] rem_next  [QW][3];
    logic [QW-1:0]   q_reg     [QW][3];
    logic [QW-1:0]   q_next    [QW][3];
    logic [SUMW-1:0] den_reg   [QW];
    logic [SUMW-1:0] den_next  [QW];
    side_t           side_reg  [QW];
    side_t           side_next [QW];
    logic [QW-1:0]   vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[QW-2:0], vld_in};
        end
    end

    always_comb begin
        logic [REMW-1:0] cur;
        logic [QW-1:0]   qcur;
        den_next[0]  = sum;
        side_next[0] = side_in;
        for (int k = 1; k < QW; k++) begin
            den_next[k]  = den_reg[k-1];
            side_next[k] = side_reg[k-1];
        end
        for (int k = 0; k < QW; k++) begin
            for (int i = 0; i < 3; i++) begin
                if (k == 0) begin
                    cur  = REMW'(sq[i]);
                    qcur = '0;
                end else begin
                    cur  = rem_reg[(k == 0) ? 0 : k-1][i] << 1;
                    qcur = q_reg[(k == 0) ? 0 : k-1][i];
                end
                if (cur >= REMW'(den_next[k])) begin
                    rem_next[k][i]   = cur - REMW'(den_next[k]);
                    qcur[QW-1-k]     = 1'b1;
                end else begin
                    rem_next[k][i]   = cur;
                end
                q_next[k][i] = qcur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            q_reg    <= q_next;
            den_reg  <= den_next;
            side_reg <= side_next;
        end
    end

    assign vld_out  = vld_reg[QW-1];
    assign quo      = q_reg[QW-1];
    assign side_out = side_reg[QW-1];

endmodule
`default_nettype wire

// ===== design/tfn_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tfn_sqrt
// Pipelined integer square root, one root bit per stage, three lanes.
// ----------------------------------------------------------------------------
module tfn_sqrt import tfn_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              vld_in,
    input  wire logic [QW-1:0]     x [3],
    input  wire side_t             side_in,
    output logic                   vld_out,
    output logic [RTW-1:0]         root [3],
    output side_t                  side_out
);

    logic [RTW-1:0] y_reg     [RTW][3];
    logic [RTW-1:0] y_next    [RTW][3];
    logic [QW-1:0]  x_reg     [RTW][3];
    logic [QW-1:0]  x_next    [RTW][3];
    side_t          side_reg  [RTW];
    side_t          side_next [RTW];
    logic [RTW-1:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[RTW-2:0], vld_in};
        end
    end

    always_comb begin
        logic [RTW-1:0]   ycur;
        logic [RTW-1:0]   t;
        logic [2*RTW-1:0] tt;
        side_next[0] = side_in;
        for (int k = 1; k < RTW; k++) begin
            side_next[k] = side_reg[k-1];
        end
        for (int k = 0; k < RTW; k++) begin
            for (int i = 0; i < 3; i++) begin
                if (k == 0) begin
                    ycur         = '0;
                    x_next[k][i] = x[i];
                end else begin
                    ycur         = y_reg[(k == 0) ? 0 : k-1][i];
                    x_next[k][i] = x_reg[(k == 0) ? 0 : k-1][i];
                end
                t            = ycur;
                t[RTW-1-k]   = 1'b1;
                tt           = t * t;
                y_next[k][i] = (tt <= (2*RTW)'(x_next[k][i])) ? t : ycur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg <= side_next;
            x_reg    <= x_next;
            y_reg    <= y_next;
        end
    end

    assign vld_out  = vld_reg[RTW-1];
    assign root     = y_reg[RTW-1];
    assign side_out = side_reg[RTW-1];

endmodule
`default_nettype wire

// ===== design/triangle_face_normal.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_face_normal
// Unit face normal of a triangle given by three corners.
// ----------------------------------------------------------------------------
// Fully pipelined: while no result waits at the output, one triangle is
// accepted per cycle and one normal leaves per cycle. Each triangle passes
// through the cross product, magnitude scaling and the sum of squares, the
// bit-per-stage divider, the bit-per-stage square root and the output
// register. The whole pipeline holds while a result waits at the output.
// A zero cross product gives degenerate set and a zero normal.
// ----------------------------------------------------------------------------
module triangle_face_normal import tfn_pkg::*; (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic signed [IN_W-1:0]  s_first_x,
    input  wire logic signed [IN_W-1:0]  s_first_y,
    input  wire logic signed [IN_W-1:0]  s_first_z,
    input  wire logic signed [IN_W-1:0]  s_second_x,
    input  wire logic signed [IN_W-1:0]  s_second_y,
    input  wire logic signed [IN_W-1:0]  s_second_z,
    input  wire logic signed [IN_W-1:0]  s_third_x,
    input  wire logic signed [IN_W-1:0]  s_third_y,
    input  wire logic signed [IN_W-1:0]  s_third_z,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic signed [OUT_W-1:0]      m_normal_x,
    output logic signed [OUT_W-1:0]      m_normal_y,
    output logic signed [OUT_W-1:0]      m_normal_z,
    output logic                         m_degenerate
);

    logic                  en;
    logic [IN_W-1:0]       p1 [3];
    logic [IN_W-1:0]       p2 [3];
    logic [IN_W-1:0]       p3 [3];
    logic                  cx_vld;
    logic signed [CXW-1:0] cross_prod [3];
    logic                  sc_vld;
    logic [SQW-1:0]        sq [3];
    logic [SUMW-1:0]       sum;
    side_t                 sc_side;
    logic                  dv_vld;
    logic [QW-1:0]         quo [3];
    side_t                 dv_side;
    logic                  rt_vld;
    logic [RTW-1:0]        root [3];
    side_t                 rt_side;

    logic                  m_valid_reg;
    logic [OUT_W-1:0]      nrm_reg  [3];
    logic [OUT_W-1:0]      nrm_next [3];
    logic                  degen_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    assign p1 = '{s_first_x,  s_first_y,  s_first_z};
    assign p2 = '{s_second_x, s_second_y, s_second_z};
    assign p3 = '{s_third_x,  s_third_y,  s_third_z};

    tfn_cross u_cross (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .vld_in     (s_valid),
        .p1         (p1),
        .p2         (p2),
        .p3         (p3),
        .vld_out    (cx_vld),
        .cross_prod (cross_prod)
    );

    tfn_scale u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .vld_in     (cx_vld),
        .cross_prod (cross_prod),
        .vld_out    (sc_vld),
        .sq         (sq),
        .sum        (sum),
        .side       (sc_side)
    );

    tfn_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .vld_in   (sc_vld),
        .sq       (sq),
        .sum      (sum),
        .side_in  (sc_side),
        .vld_out  (dv_vld),
        .quo      (quo),
        .side_out (dv_side)
    );

    tfn_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .vld_in   (dv_vld),
        .x        (quo),
        .side_in  (dv_side),
        .vld_out  (rt_vld),
        .root     (root),
        .side_out (rt_side)
    );

    // round to nearest from the root of (2r-1)^2 bound, cap at one
    always_comb begin
        logic [RTW:0]   half;
        logic [OUT_W-1:0] r;
        for (int i = 0; i < 3; i++) begin
            half = (RTW+1)'(({1'b0, root[i]} + (RTW+1)'(1)) >> 1);
            r    = (half > (RTW+1)'(ONE_OUT)) ? ONE_OUT : OUT_W'(half);
            if (rt_side.degen) begin
                nrm_next[i] = '0;
            end else if (rt_side.neg[i]) begin
                nrm_next[i] = OUT_W'(-r);
            end else begin
                nrm_next[i] = r;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= rt_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nrm_reg   <= nrm_next;
            degen_reg <= rt_side.degen;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_normal_x   = nrm_reg[0];
    assign m_normal_y   = nrm_reg[1];
    assign m_normal_z   = nrm_reg[2];
    assign m_degenerate = degen_reg;

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> m_normal_x == '0 && m_normal_y == '0 && m_normal_z == '0)
        else $error("degenerate result with nonzero normal");

    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_normal_x <= 16'sd16384 && m_normal_x >= -16'sd16384
                 && m_normal_y <= 16'sd16384 && m_normal_y >= -16'sd16384
                 && m_normal_z <= 16'sd16384 && m_normal_z >= -16'sd16384)
        else $error("normal component beyond one");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_normal_x) && $stable(m_degenerate))
        else $error("stalled item changed");

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Checks the triangle face normal pipeline against an in-bench predictor.
// ----------------------------------------------------------------------------
// Directed triangles (extreme corners, degenerate and axis-aligned faces)
// are followed by random ones. A clocked driver sends the pending items with
// random gaps, a clocked monitor stalls at random and compares every normal
// with the oldest predicted one.
// ----------------------------------------------------------------------------
module testbench import tfn_pkg::*; ();

    typedef struct {
        logic signed [IN_W-1:0] crd [9];
    } tri_t;

    typedef struct {
        logic signed [OUT_W-1:0] nx, ny, nz;
        logic                    degen;
    } normal_t;

    localparam int LATENCY    = 56;
    localparam int STALL_LIMIT = 2000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [IN_W-1:0] s_crd [9] = '{default: '0};
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [OUT_W-1:0] m_normal_x, m_normal_y, m_normal_z;
    logic m_degenerate;

    tri_t    pending_tris[$];
    normal_t expected_normals[$];
    int      n_errors = 0;
    int      n_checked = 0;
    int      n_degen = 0;
    int      idle_cycles = 0;
    int      cycle_cnt = 0;
    bit      stimulus_done = 1'b0;

    always #5 aclk = ~aclk;

    triangle_face_normal i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_first_x(s_crd[0]), .s_first_y(s_crd[1]), .s_first_z(s_crd[2]),
        .s_second_x(s_crd[3]), .s_second_y(s_crd[4]), .s_second_z(s_crd[5]),
        .s_third_x(s_crd[6]), .s_third_y(s_crd[7]), .s_third_z(s_crd[8]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_normal_x(m_normal_x), .m_normal_y(m_normal_y),
        .m_normal_z(m_normal_z), .m_degenerate(m_degenerate)
    );

    function automatic logic [15:0] rounded_unit(longint unsigned m, longint unsigned s);
        longint unsigned r, t, q, rhs;
        r = 0;
        rhs = (m * m) << 30;
        for (int b = FRAC_OUT; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t <= 16384) begin
                q = 2 * t - 1;
                if (q * q * s <= rhs) r = t;
            end
        end
        return r[15:0];
    endfunction

    function automatic normal_t face_normal(tri_t t);
        normal_t n;
        longint p [9];
        longint e1 [3], e2 [3], c [3];
        longint unsigned m [3], top, s;
        logic [15:0] r;
        int sh;
        for (int i = 0; i < 9; i++) p[i] = longint'(t.crd[i]);
        for (int i = 0; i < 3; i++) begin
            e1[i] = p[3 + i] - p[i];
            e2[i] = p[6 + i] - p[i];
        end
        c[0] = e1[1] * e2[2] - e1[2] * e2[1];
        c[1] = e1[2] * e2[0] - e1[0] * e2[2];
        c[2] = e1[0] * e2[1] - e1[1] * e2[0];
        n.nx = 0; n.ny = 0; n.nz = 0; n.degen = 1'b1;
        if (c[0] == 0 && c[1] == 0 && c[2] == 0) return n;
        top = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = c[i] < 0 ? longint'(-c[i]) : c[i];
            if (m[i] > top) top = m[i];
        end
        sh = 0;
        while ((top >> sh) >= 64'd65536) sh++;
        for (int i = 0; i < 3; i++) m[i] = m[i] >> sh;
        s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        for (int i = 0; i < 3; i++) begin
            r = rounded_unit(m[i], s);
            if (c[i] < 0) r = -r;
            if (i == 0) n.nx = r;
            else if (i == 1) n.ny = r;
            else n.nz = r;
        end
        n.degen = 1'b0;
        return n;
    endfunction

    function automatic logic [15:0] rand_coord(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 64)) - 32);
            2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return 16'($signed($urandom_range(0, 2048)) - 1024);
        endcase
    endfunction

    // stimulus
    initial begin
        tri_t t;
        int mode;
        int k;
        for (int i = 0; i < 9; i++) t.crd[i] = 0;
        pending_tris.push_back(t);
        for (int i = 0; i < 9; i++) t.crd[i] = 16'h7fff;
        pending_tris.push_back(t);
        t.crd = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
                  16'h8000, 16'h7fff, 16'h8000};
        pending_tris.push_back(t);
        t.crd = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
                  16'h8000, 16'h7fff, 16'h7fff};
        pending_tris.push_back(t);
        t.crd = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff,
                  16'h7fff, 16'h7fff, 16'h8000};
        pending_tris.push_back(t);
        // unit faces in each plane, both windings for the xy plane
        t.crd = '{0, 0, 0, 256, 0, 0, 0, 256, 0};
        pending_tris.push_back(t);
        t.crd = '{0, 0, 0, 0, 256, 0, 256, 0, 0};
        pending_tris.push_back(t);
        t.crd = '{0, 0, 0, 0, 256, 0, 0, 0, 256};
        pending_tris.push_back(t);
        t.crd = '{0, 0, 0, 0, 0, 256, 256, 0, 0};
        pending_tris.push_back(t);
        t.crd = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
        pending_tris.push_back(t);
        // collinear and coincident corners
        t.crd = '{10, 20, 30, 20, 40, 60, 40, 80, 120};
        pending_tris.push_back(t);
        t.crd = '{-5, 7, 9, -5, 7, 9, 100, -3, 2};
        pending_tris.push_back(t);
        // tiny component next to huge ones, truncated by the shift
        t.crd = '{0, 0, 0, 16'h7fff, 1, 0, 0, 16'h7fff, 0};
        pending_tris.push_back(t);
        t.crd = '{0, 0, 0, 16'h7fff, 16'h7fff, 1, 16'h8000, 16'h7fff, 0};
        pending_tris.push_back(t);
        t.crd = '{1, -1, 1, -1, 1, -1, 2, 3, -4};
        pending_tris.push_back(t);
        for (int n = 0; n < 600; n++) begin
            mode = $urandom_range(0, 3);
            for (int i = 0; i < 9; i++) t.crd[i] = rand_coord(mode);
            k = $urandom_range(0, 19);
            if (k == 0) begin
                for (int i = 0; i < 3; i++) t.crd[3 + i] = t.crd[i];
            end else if (k == 1) begin
                for (int i = 0; i < 3; i++) t.crd[6 + i] = 16'(2 * t.crd[3 + i] - t.crd[i]);
            end
            pending_tris.push_back(t);
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // driver
    always @(posedge aclk) begin
        tri_t t;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_normals.push_back(face_normal(pending_tris.pop_front()));
            end
            if ((!s_valid || s_ready)) begin
                if (pending_tris.size() != 0 &&
                    ((cycle_cnt > 150 && cycle_cnt < 450) || $urandom_range(0, 99) >= 7)) begin
                    t = pending_tris[0];
                    s_valid <= 1'b1;
                    for (int i = 0; i < 9; i++) s_crd[i] <= t.crd[i];
                end else begin
                    s_valid <= 1'b0;
                end
            end
            if (pending_tris.size() == 0 && !(s_valid && !s_ready)) stimulus_done <= 1'b1;
        end
    end

    // monitor
    always @(posedge aclk) begin
        normal_t e;
        if (aresetn) begin
            cycle_cnt <= cycle_cnt + 1;
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (m_valid && m_ready) begin
                if (expected_normals.size() == 0) begin
                    $error("normal with no triangle pending");
                    n_errors++;
                end else begin
                    e = expected_normals.pop_front();
                    n_checked <= n_checked + 1;
                    if (e.degen) n_degen <= n_degen + 1;
                    if (m_normal_x !== e.nx) begin
                        $error("normal_x expected %0d actual %0d", e.nx, m_normal_x);
                        n_errors++;
                    end
                    if (m_normal_y !== e.ny) begin
                        $error("normal_y expected %0d actual %0d", e.ny, m_normal_y);
                        n_errors++;
                    end
                    if (m_normal_z !== e.nz) begin
                        $error("normal_z expected %0d actual %0d", e.nz, m_normal_z);
                        n_errors++;
                    end
                    if (m_degenerate !== e.degen) begin
                        $error("degenerate expected %0d actual %0d", e.degen, m_degenerate);
                        n_errors++;
                    end
                end
            end
            m_ready <= (cycle_cnt > 150 && cycle_cnt < 450) || $urandom_range(0, 99) >= 7;
        end
    end

    // end of run and watchdog
    initial begin
        @(posedge aresetn);
        while (!(stimulus_done && expected_normals.size() == 0) && idle_cycles < STALL_LIMIT)
            @(posedge aclk);
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
        end else begin
            repeat (2 * LATENCY) @(posedge aclk);
            $display("checked %0d normals, %0d of them degenerate", n_checked, n_degen);
            if (n_errors == 0 && m_valid !== 1'b1) begin
                $display("All tests passed");
            end else begin
                $display("Some tests failed");
            end
        end
        $finish;
    end

endmodule
`default_nettype wire
